// ===== src/ets_pkg.sv =====
package ets_pkg;

  // offset added in local time mode, eight hours in seconds
  localparam logic [32:0] LOCAL_OFFSET_SEC = 33'd28800;

  // seconds per day is 2^7 * 675, the high part is divided by 675
  localparam logic [9:0]  DAY_HI_DIV    = 10'd675;
  // ceil(2^36 / 675), exact for a 26 bit dividend
  localparam logic [26:0] DAY_HI_RECIP  = 27'd101806633;
  // ceil(2^25 / 365), exact for a 16 bit dividend
  localparam logic [16:0] YEAR_RECIP    = 17'd91930;
  // ceil(2^21 / 225), exact for the 13 bit seconds-of-day / 16
  localparam logic [13:0] HOUR_RECIP    = 14'd9321;
  // ceil(2^19 / 7), exact for a 16 bit dividend
  localparam logic [16:0] WEEK_RECIP    = 17'd74899;
  // ceil(2^14 / 15), exact for the 10 bit seconds-of-hour / 4
  localparam logic [10:0] MIN_RECIP     = 11'd1093;

  localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [11:0] SEC_PER_MIN   = 12'd60;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  // weekday offset: the epoch day is a thursday
  localparam logic [16:0] WEEK_OFFSET   = 17'd3;
  localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
  // year offset of 2100, the only century year in range that is not a leap year
  localparam logic [7:0]  CENTURY_OFF   = 8'd130;
  localparam int          NUM_MONTHS    = 12;

  // first day of year 1970+k, counted in days since the epoch
  function automatic logic [15:0] year_start(input logic [7:0] k);
    logic [8:0]  kp1;
    logic [16:0] base;
    kp1  = {1'b0, k} + 9'd1;
    base = 17'(k) * 17'd365 + 17'(kp1[8:2]) - 17'(k > CENTURY_OFF);
    return base[15:0];
  endfunction

  // first day of month m (0 is january) within its year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((leap && (m >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

// ===== src/ets_if.sv =====
interface ets_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ets_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  output ready);
endinterface

interface ets_cfg_if;
  logic valid;
  logic ready;
  logic add_eight_hours;

  modport source (output valid, output add_eight_hours, input ready);
  modport sink   (input valid, input add_eight_hours, output ready);
endinterface

// ===== src/epoch_seconds_to_calendar_unit.sv =====
// epoch seconds to calendar date and time
//
// item_i carries a 32 bit count of seconds since 1970-01-01 00:00:00 utc.
// result_o returns year, month, day_of_month, hour, minute, second and
// weekday (1 monday .. 7 sunday) for that item, one result per item, in order.
// cfg_i writes the mode bit: 1 adds eight hours (utc+8), 0 gives plain utc.
// cfg_i is always ready; write it only while no item is in flight.
//
// the datapath is a seven stage pipeline with a valid bit per stage.
// an accepted item passes through stages 0 to 6 and its result is offered from
// the stage 6 output register; one item can be accepted every cycle while
// item_i.ready is high. the widest stage, the 26 x 27 bit reciprocal multiply
// that splits days from seconds of day, bounds the clock period, not the item rate.
// when result_o stalls, the result holds in the output stage and items
// keep moving forward into empty stages; item_i.ready drops only once
// every stage ahead of the input is occupied. nothing is lost or repeated.
//
// reset clears all stage valid bits and sets the mode to plain utc.
module epoch_seconds_to_calendar_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ets_cfg_if.sink      cfg_i,
  ets_item_if.sink     item_i,
  ets_result_if.source result_o
);

  localparam int STAGES = 7;

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] adv;
  logic              mode_q;

  // a stage may load when it is empty or its item moves on
  always_comb begin
    adv[STAGES-1] = !v_q[STAGES-1] || result_o.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign item_i.ready = adv[0];
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      mode_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        mode_q <= cfg_i.add_eight_hours;
      end
      if (adv[0]) begin
        v_q[0] <= item_i.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 0: apply the time zone offset, 33 bits so nothing wraps
  logic [32:0] t0_d, t0_q;
  assign t0_d = {1'b0, item_i.epoch_seconds} +
                (mode_q ? ets_pkg::LOCAL_OFFSET_SEC : 33'd0);

  // stage 1: days = (t >> 7) / 675 by reciprocal multiply
  logic [52:0] prod1;
  logic [15:0] days1_d, days1_q;
  logic [32:0] t1_q;
  assign prod1   = 53'(t0_q[32:7]) * 53'(ets_pkg::DAY_HI_RECIP);
  assign days1_d = prod1[51:36];

  // stage 2: seconds of day from the remainder
  logic [25:0] dprod2, r2;
  logic [16:0] rem2_d, rem2_q;
  logic [15:0] days2_q;
  assign dprod2 = 26'(days1_q) * 26'(ets_pkg::DAY_HI_DIV);
  assign r2     = t1_q[32:7] - dprod2;
  assign rem2_d = {r2[9:0], t1_q[6:0]};

  // stage 3: year estimate days/365 (true year or one above), hour, week quotient
  logic [32:0] yprod3;
  logic [26:0] hprod3;
  logic [16:0] wsum3;
  logic [33:0] wprod3;
  logic [7:0]  yest3_d, yest3_q;
  logic [4:0]  hour3_d, hour3_q;
  logic [12:0] wq3_d, wq3_q;
  logic [15:0] days3_q;
  logic [16:0] rem3_q;
  assign yprod3  = 33'(days2_q) * 33'(ets_pkg::YEAR_RECIP);
  assign yest3_d = yprod3[32:25];
  assign hprod3  = 27'(rem2_q[16:4]) * 27'(ets_pkg::HOUR_RECIP);
  assign hour3_d = hprod3[25:21];
  assign wsum3   = 17'(days2_q) + ets_pkg::WEEK_OFFSET;
  assign wprod3  = 34'(wsum3) * 34'(ets_pkg::WEEK_RECIP);
  assign wq3_d   = wprod3[31:19];

  // stage 4: correct the year estimate, day of year, seconds of hour, weekday
  logic [15:0] ys_est4, ys_prev4, ys_sel4, dsub4;
  logic [7:0]  yprev4;
  logic        below4;
  logic [16:0] hsub4, wsum4, wsub4;
  logic [7:0]  yoff4_d, yoff4_q;
  logic [8:0]  doy4_d, doy4_q;
  logic [11:0] hrem4_d, hrem4_q;
  logic [2:0]  wday4_d, wday4_q;
  logic [4:0]  hour4_q;
  assign yprev4   = yest3_q - 8'd1;
  assign ys_est4  = ets_pkg::year_start(yest3_q);
  assign ys_prev4 = ets_pkg::year_start(yprev4);
  assign below4   = days3_q < ys_est4;
  assign yoff4_d  = below4 ? yprev4 : yest3_q;
  assign ys_sel4  = below4 ? ys_prev4 : ys_est4;
  assign dsub4    = days3_q - ys_sel4;
  assign doy4_d   = dsub4[8:0];
  assign hsub4    = rem3_q - 17'(hour3_q) * ets_pkg::SEC_PER_HOUR;
  assign hrem4_d  = hsub4[11:0];
  assign wsum4    = 17'(days3_q) + ets_pkg::WEEK_OFFSET;
  assign wsub4    = wsum4 - 17'(wq3_q) * ets_pkg::DAYS_PER_WEEK;
  assign wday4_d  = wsub4[2:0] + 3'd1;

  // stage 5: leap flag, month by parallel compare, minute
  logic        leap5_d, leap5_q;
  logic [3:0]  month5_d, month5_q;
  logic [20:0] mprod5;
  logic [5:0]  min5_d, min5_q;
  logic [7:0]  yoff5_q;
  logic [8:0]  doy5_q;
  logic [11:0] hrem5_q;
  logic [4:0]  hour5_q;
  logic [2:0]  wday5_q;
  assign leap5_d = (yoff4_q[1:0] == 2'd2) && (yoff4_q != ets_pkg::CENTURY_OFF);
  always_comb begin
    month5_d = 4'd0;
    for (int m = 1; m < ets_pkg::NUM_MONTHS; m++) begin
      month5_d = month5_d +
                 4'((doy4_q >= ets_pkg::month_start(4'(m), leap5_d)) ? 1 : 0);
    end
  end
  assign mprod5 = 21'(hrem4_q[11:2]) * 21'(ets_pkg::MIN_RECIP);
  assign min5_d = mprod5[19:14];

  // stage 6: output register, final subtractions
  logic [8:0]  dsub6;
  logic [11:0] ssub6;
  logic [11:0] year6_q;
  logic [3:0]  month6_q;
  logic [4:0]  day6_q;
  logic [4:0]  hour6_q;
  logic [5:0]  min6_q, sec6_q;
  logic [2:0]  wday6_q;
  assign dsub6 = doy5_q - ets_pkg::month_start(month5_q, leap5_q) + 9'd1;
  assign ssub6 = hrem5_q - 12'(min5_q) * ets_pkg::SEC_PER_MIN;

  // payload registers, loaded with their stage
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      t0_q <= t0_d;
    end
    if (adv[1]) begin
      t1_q    <= t0_q;
      days1_q <= days1_d;
    end
    if (adv[2]) begin
      days2_q <= days1_q;
      rem2_q  <= rem2_d;
    end
    if (adv[3]) begin
      days3_q <= days2_q;
      rem3_q  <= rem2_q;
      yest3_q <= yest3_d;
      hour3_q <= hour3_d;
      wq3_q   <= wq3_d;
    end
    if (adv[4]) begin
      yoff4_q <= yoff4_d;
      doy4_q  <= doy4_d;
      hrem4_q <= hrem4_d;
      hour4_q <= hour3_q;
      wday4_q <= wday4_d;
    end
    if (adv[5]) begin
      yoff5_q  <= yoff4_q;
      doy5_q   <= doy4_q;
      hrem5_q  <= hrem4_q;
      hour5_q  <= hour4_q;
      wday5_q  <= wday4_q;
      leap5_q  <= leap5_d;
      month5_q <= month5_d;
      min5_q   <= min5_d;
    end
    if (adv[6]) begin
      year6_q  <= ets_pkg::EPOCH_YEAR + 12'(yoff5_q);
      month6_q <= month5_q + 4'd1;
      day6_q   <= dsub6[4:0];
      hour6_q  <= hour5_q;
      min6_q   <= min5_q;
      sec6_q   <= ssub6[5:0];
      wday6_q  <= wday5_q;
    end
  end

  assign result_o.valid        = v_q[STAGES-1];
  assign result_o.year         = year6_q;
  assign result_o.month        = month6_q;
  assign result_o.day_of_month = day6_q;
  assign result_o.hour         = hour6_q;
  assign result_o.minute       = min6_q;
  assign result_o.second       = sec6_q;
  assign result_o.weekday      = wday6_q;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> v_q[0])
    else $error("accepted item did not enter the first stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && !adv[4]) |=> v_q[3])
    else $error("stalled item dropped from the middle stage");

  a_doy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (doy4_q < 9'd366))
    else $error("day of year out of range after year correction");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ((result_o.month >= 4'd1) && (result_o.month <= 4'd12) &&
                        (result_o.day_of_month >= 5'd1)))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ((result_o.hour < 5'd24) && (result_o.minute < 6'd60) &&
                        (result_o.second < 6'd60) && (result_o.weekday != 3'd0)))
    else $error("time of day or weekday out of range");
`endif

endmodule

// ===== sim/tb_epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_unit;

  // calendar constants for the expected-value calculation
  localparam longint unsigned DAY_SECS   = 86400;
  localparam longint unsigned HOUR_SECS  = 3600;
  localparam longint unsigned MIN_SECS   = 60;
  localparam longint unsigned UTC8_SECS  = 8 * 3600;
  localparam int unsigned     FIRST_YEAR = 1970;
  // pipeline depth plus some slack, waited out before the final verdict
  localparam int              DRAIN_CYCLES = 20;
  // worst case is roughly 550 items, each with the longest send gap and receive stall
  localparam int              CYCLE_LIMIT  = 400000;
  localparam int              RANDOM_PHASES = 4;
  localparam int              ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  logic clk = 1'b0;
  logic rst_n;

  ets_cfg_if    cfg_bus ();
  ets_item_if   item_bus ();
  ets_result_if result_bus ();

  epoch_seconds_to_calendar_unit DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] epoch_q [$];      // timestamps waiting to be sent
  calendar_t   calendar_q [$];   // expected dates, oldest first
  logic        local_time_on;    // testbench copy of the mode bit
  int          send_idle_pct;    // chance of a gap after each item sent
  int          recv_idle_pct;    // chance of a stall after each ready cycle
  int          send_gap;
  int          recv_stall;
  int          errors;
  int          cycles;
  calendar_t   want;

  // boundary timestamps: epoch, end of range, midnight, leap and century rules,
  // and the spots where utc+8 rolls over a day, month or year
  logic [31:0] corner_secs [$] = '{
    32'd0,          32'hFFFF_FFFF,  32'd86399,      32'd86400,
    32'd94694399,   32'd951782400,  32'd951868800,  32'd946655999,
    32'd946656000,  32'd983376000,  32'd4107542399, 32'd4107542400
  };

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // full conversion from epoch seconds to the calendar fields
  function automatic calendar_t to_calendar(input logic [31:0] secs, input logic plus8);
    longint unsigned t;
    longint unsigned days;
    longint unsigned sod;
    int unsigned     yr;
    int unsigned     mo;
    int unsigned     ylen;
    int unsigned     mlen;
    int unsigned     mdays [12];
    calendar_t       c;
    mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    t = longint'(secs);
    if (plus8) t += UTC8_SECS;
    days = t / DAY_SECS;
    sod  = t % DAY_SECS;
    // the epoch day is a thursday, monday counts as 1
    c.weekday = 3'((days + 3) % 7 + 1);
    yr = FIRST_YEAR;
    forever begin
      ylen = is_leap(yr) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    mo = 0;
    while (mo < 11) begin
      mlen = mdays[mo];
      if (mo == 1 && is_leap(yr)) mlen = 29;
      if (days < mlen) break;
      days -= mlen;
      mo++;
    end
    c.year         = 12'(yr);
    c.month        = 4'(mo + 1);
    c.day_of_month = 5'(days + 1);
    c.hour         = 5'(sod / HOUR_SECS);
    c.minute       = 6'((sod % HOUR_SECS) / MIN_SECS);
    c.second       = 6'(sod % MIN_SECS);
    return c;
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // random timestamp: uniform, just before a midnight (mostly within the utc+8 window
  // so rollovers hit both modes), or close to either end of the range
  function automatic logic [31:0] random_secs();
    longint unsigned d;
    int              pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom();
    if (pick < 8) begin
      d = $urandom_range(1, 49710);
      return 32'(d * DAY_SECS - $urandom_range(1, 30000));
    end
    if (pick == 8) return $urandom_range(0, 100000);
    return 32'hFFFF_FFFF - $urandom_range(0, 100000);
  endfunction

  // item driver: takes timestamps from the queue, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      item_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_bus.valid && item_bus.ready)
        calendar_q.push_back(to_calendar(item_bus.epoch_seconds, local_time_on));
      // the bus is free when nothing is offered or the offer was just taken
      if (!item_bus.valid || item_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_bus.valid <= 1'b0;
        end else if (epoch_q.size() > 0) begin
          item_bus.valid         <= 1'b1;
          item_bus.epoch_seconds <= epoch_q.pop_front();
          if ($urandom_range(0, 99) < send_idle_pct) send_gap = pick_gap();
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, compares against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (calendar_q.size() == 0) begin
          $error("result item with no expected date pending");
          errors++;
        end else begin
          want = calendar_q.pop_front();
          check_field("year", want.year, result_bus.year);
          check_field("month", want.month, result_bus.month);
          check_field("day_of_month", want.day_of_month, result_bus.day_of_month);
          check_field("hour", want.hour, result_bus.hour);
          check_field("minute", want.minute, result_bus.minute);
          check_field("second", want.second, result_bus.second);
          check_field("weekday", want.weekday, result_bus.weekday);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < recv_idle_pct) recv_stall = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // block until every queued item has gone through and been checked,
  // sampled at the falling edge so the rising-edge updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (epoch_q.size() != 0 || item_bus.valid || calendar_q.size() != 0);
  endtask

  // mode write, only issued with the pipeline empty
  task automatic write_mode(input logic plus8);
    wait_idle();
    @(posedge clk);
    cfg_bus.valid           <= 1'b1;
    cfg_bus.add_eight_hours <= plus8;
    do @(posedge clk);
    while (!cfg_bus.ready);
    local_time_on = plus8;
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    errors        = 0;
    cycles        = 0;
    local_time_on = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    rst_n                   = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.add_eight_hours = 1'b0;
    item_bus.valid          = 1'b0;
    item_bus.epoch_seconds  = '0;
    result_bus.ready        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner timestamps in plain utc straight out of reset, then in utc+8
    foreach (corner_secs[i]) epoch_q.push_back(corner_secs[i]);
    write_mode(1'b1);
    foreach (corner_secs[i]) epoch_q.push_back(corner_secs[i]);
    write_mode(1'b0);

    // random phases, alternating mode and idle pressure, one phase with none
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mode(p[0] ^ 1'b1);
      case (p)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 50; recv_idle_pct = 10; end
        2: begin send_idle_pct = 10; recv_idle_pct = 50; end
        default: begin send_idle_pct = 40; recv_idle_pct = 40; end
      endcase
      repeat (ITEMS_PER_PHASE) epoch_q.push_back(random_secs());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && calendar_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
